/* src/sss_pkg.sv */
// Package for the selection sort stepper: sizes, command codes and the
// types that pass between the top level and its row of cells. No dependencies.
package sss_pkg;

   localparam int DEPTH     = 64;
   localparam int DATA_W    = 32;
   localparam int CNT_W     = 7;
   localparam int IDX_W     = 6;
   localparam int OP_W      = 2;
   localparam int POS_W     = ($clog2(DEPTH) > CNT_W) ? $clog2(DEPTH) : CNT_W;
   localparam int CNT_LIMIT = (DEPTH > 127) ? 127 : DEPTH;

   localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_STEP    = 2'd1;
   localparam logic [OP_W-1:0] OP_READ    = 2'd2;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd3;

   localparam logic [1:0] CSR_ELEMENT_COUNT = 2'd0;

   typedef struct packed {
      logic                     valid;
      logic                     is_read;
      logic                     is_step;
      logic [POS_W-1:0]         idx;
      logic [POS_W-1:0]         first;
      logic [POS_W-1:0]         n;
      logic [POS_W-1:0]         best_idx;
      logic signed [DATA_W-1:0] best_val;
      logic signed [DATA_W-1:0] first_val;
      logic signed [DATA_W-1:0] rd_val;
   } token_type;

   typedef struct packed {
      logic                     a_en;
      logic [POS_W-1:0]         a_pos;
      logic signed [DATA_W-1:0] a_data;
      logic                     b_en;
      logic [POS_W-1:0]         b_pos;
      logic signed [DATA_W-1:0] b_data;
   } write_type;

endpackage

/* src/sss_cell.sv */
// One cell of the sorting row: holds one element and passes the scan token on.
// Depends on sss_pkg.
module sss_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic [sss_pkg::POS_W-1:0] cell_index,
   input  sss_pkg::write_type wr,
   input  sss_pkg::token_type token_in,
   output sss_pkg::token_type token_out
);
   import sss_pkg::*;

   logic signed [DATA_W-1:0] elem_ff;
   logic signed [DATA_W-1:0] elem_in;
   token_type                token_ff;
   token_type                token_in_next;

   always_comb begin
      elem_in = elem_ff;
      if (wr.a_en && (wr.a_pos == cell_index)) begin
         elem_in = wr.a_data;
      end else if (wr.b_en && (wr.b_pos == cell_index)) begin
         elem_in = wr.b_data;
      end
   end

   always_comb begin
      token_in_next = token_in;
      if (token_in.is_read && (token_in.idx == cell_index)) begin
         token_in_next.rd_val = elem_ff;
      end
      if (token_in.is_step) begin
         if (cell_index == token_in.first) begin
            token_in_next.first_val = elem_ff;
            token_in_next.best_val  = elem_ff;
            token_in_next.best_idx  = cell_index;
         end else if ((cell_index > token_in.first) && (cell_index < token_in.n)
                      && (elem_ff < token_in.best_val)) begin
            token_in_next.best_val = elem_ff;
            token_in_next.best_idx = cell_index;
         end
      end
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
      if (reset) begin
         token_ff <= '0;
      end else begin
         token_ff <= token_in_next;
      end
   end

   assign token_out = token_ff;

endmodule

/* src/selection_sort_stepper.sv */
// Selection sort stepper: a row of element cells scanned by a travelling token.
// Depends on sss_pkg and sss_cell.
//
// Items arrive on the req_ channel (opcode, index, value) and each gives one
// result item on the rsp_ channel (read_value, sorted_count, done_res).
// element_count is written through the APB-style port at address 0.
// A load or restart item gives its result in the cycle after it is accepted.
// A sort step or a read sends a token down the row of DEPTH cells, one cell
// per cycle; each cell compares or supplies its element as the token passes,
// and the swap of a step is written into the two cells as the token leaves.
// Such an item passes through the DEPTH cell registers and the output register,
// and the block works on one item at a time; a new item may be accepted while
// the last result is being taken.
// A result waits in the output register while rsp_stall is high; the block
// then stalls further items. Reset empties the row and the output register,
// clears the sorted count and element_count; element contents are undefined
// until loaded.
module selection_sort_stepper (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sss_pkg::OP_W-1:0]    req_opcode,
   input  logic [sss_pkg::IDX_W-1:0]   req_index,
   input  logic signed [sss_pkg::DATA_W-1:0] req_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [sss_pkg::DATA_W-1:0] rsp_read_value,
   output logic [sss_pkg::CNT_W-1:0]   rsp_sorted_count,
   output logic                        rsp_done_res,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [1:0]                  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import sss_pkg::*;

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [CNT_W-1:0]         prefix_ff;
   logic [CNT_W-1:0]         prefix_in;
   logic                     busy_ff;
   logic                     busy_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_read_ff;
   logic signed [DATA_W-1:0] rsp_read_in;
   logic [CNT_W-1:0]         rsp_count_ff;
   logic [CNT_W-1:0]         rsp_count_in;
   logic                     rsp_done_ff;
   logic                     rsp_done_in;

   logic [CNT_W-1:0] eff_count;
   logic             accept;
   logic             launch;
   logic             quick;
   logic             swap_en;
   token_type        tok [DEPTH+1];
   token_type        chain_out;
   write_type        wr;

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_ELEMENT_COUNT) ? {{(32-CNT_W){1'b0}}, count_ff} : 32'd0;

   always_comb begin
      count_in = count_ff;
      if (psel && penable && pwrite && (paddr == CSR_ELEMENT_COUNT)) begin
         count_in = pwdata[CNT_W-1:0];
      end
   end

   assign eff_count = (count_ff > CNT_W'(CNT_LIMIT)) ? CNT_W'(CNT_LIMIT) : count_ff;

   assign req_stall = busy_ff || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign launch    = accept && ((req_opcode == OP_STEP) || (req_opcode == OP_READ));
   assign quick     = accept && ((req_opcode == OP_LOAD) || (req_opcode == OP_RESTART));

   always_comb begin
      tok[0]           = '0;
      tok[0].valid     = launch;
      tok[0].is_read   = launch && (req_opcode == OP_READ);
      tok[0].is_step   = launch && (req_opcode == OP_STEP);
      tok[0].idx       = POS_W'(req_index);
      tok[0].first     = POS_W'(prefix_ff);
      tok[0].n         = POS_W'(eff_count);
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      sss_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (POS_W'(i)),
         .wr         (wr),
         .token_in   (tok[i]),
         .token_out  (tok[i+1])
      );
   end

   assign chain_out = tok[DEPTH];
   assign swap_en   = chain_out.valid && chain_out.is_step && (chain_out.first < chain_out.n);

   always_comb begin
      wr = '0;
      if (accept && (req_opcode == OP_LOAD)) begin
         wr.a_en   = 1'b1;
         wr.a_pos  = POS_W'(req_index);
         wr.a_data = req_value;
      end else if (swap_en) begin
         wr.a_en   = 1'b1;
         wr.a_pos  = chain_out.first;
         wr.a_data = chain_out.best_val;
         wr.b_en   = 1'b1;
         wr.b_pos  = chain_out.best_idx;
         wr.b_data = chain_out.first_val;
      end
   end

   always_comb begin
      prefix_in = prefix_ff;
      if (accept && (req_opcode == OP_RESTART)) begin
         prefix_in = '0;
      end else if (swap_en) begin
         prefix_in = prefix_ff + CNT_W'(1);
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (launch) begin
         busy_in = 1'b1;
      end else if (chain_out.valid) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_read_in  = rsp_read_ff;
      rsp_count_in = rsp_count_ff;
      rsp_done_in  = rsp_done_ff;
      if (quick || chain_out.valid) begin
         rsp_valid_in = 1'b1;
         rsp_read_in  = (chain_out.valid && chain_out.is_read) ? chain_out.rd_val : '0;
         rsp_count_in = prefix_in;
         rsp_done_in  = (prefix_in >= eff_count);
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_ff  <= rsp_read_in;
      rsp_count_ff <= rsp_count_in;
      rsp_done_ff  <= rsp_done_in;
      if (reset) begin
         count_ff     <= '0;
         prefix_ff    <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         prefix_ff    <= prefix_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_read_ff;
   assign rsp_sorted_count = rsp_count_ff;
   assign rsp_done_res     = rsp_done_ff;

endmodule

/* src/sss_checker.sv */
// Port-level checks for the selection sort stepper, bound to its top level.
// Depends on sss_pkg and selection_sort_stepper.
module sss_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic signed [sss_pkg::DATA_W-1:0] rsp_read_value,
   input logic [sss_pkg::CNT_W-1:0]   rsp_sorted_count,
   input logic                        rsp_done_res
);
   import sss_pkg::*;

   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid in the cycle after reset");

   a_stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_sorted_count) && $stable(rsp_done_res))
      else $error("stalled result item changed");

   a_no_accept_when_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> !(req_valid && !req_stall))
      else $error("item accepted while a result is held");

   a_count_below_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |-> rsp_sorted_count < CNT_W'(CNT_LIMIT))
      else $error("sorted count at its limit without done");

endmodule

bind selection_sort_stepper sss_checker u_sss_checker (.*);

/* tb/tb_selection_sort_stepper.sv */
// Self-checking testbench for the selection sort stepper, with a scoreboard class
// that predicts every result item. Depends on sss_pkg and selection_sort_stepper.
// Drives the req_ and APB ports with plain tasks and checks the rsp_ items.
module tb_selection_sort_stepper;
   timeunit 1ns;
   timeprecision 1ps;
   import sss_pkg::*;

   localparam int RUN_LIMIT   = 1_000_000;
   localparam int HOLD_LEN    = 300;
   localparam int ITEM_TARGET = 1500;

   typedef struct {
      logic signed [DATA_W-1:0] read_value;
      logic [CNT_W-1:0]         sorted_count;
      logic                     done_res;
   } sort_result_type;

   class sort_scoreboard_type;
      logic signed [DATA_W-1:0] cells [DEPTH];
      bit                       loaded [DEPTH];
      logic [CNT_W-1:0]         prefix;
      logic [CNT_W-1:0]         count_reg;
      sort_result_type          expected_q [$];
      int                       errors;

      function void clear();
         foreach (cells[i]) begin
            cells[i]  = '0;
            loaded[i] = 0;
         end
         prefix    = '0;
         count_reg = '0;
         errors    = 0;
         expected_q.delete();
      endfunction

      function int live_count();
         return (count_reg > DEPTH) ? DEPTH : int'(count_reg);
      endfunction

      function void set_element_count(logic [31:0] data);
         count_reg = data[CNT_W-1:0];
      endfunction

      function bit step_safe();
         for (int i = prefix; i < live_count(); i++)
            if (!loaded[i]) return 0;
         return 1;
      endfunction

      function void note_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                              logic signed [DATA_W-1:0] val);
         sort_result_type          r;
         int                       best;
         logic signed [DATA_W-1:0] t;
         r.read_value = '0;
         case (op)
            OP_LOAD: begin
               cells[idx]  = val;
               loaded[idx] = 1;
            end
            OP_STEP: begin
               if (prefix < live_count()) begin
                  best = prefix;
                  for (int i = prefix + 1; i < live_count(); i++)
                     if (cells[i] < cells[best]) best = i;
                  t            = cells[prefix];
                  cells[prefix] = cells[best];
                  cells[best]  = t;
                  prefix       = CNT_W'(prefix + 1);
               end
            end
            OP_READ: r.read_value = cells[idx];
            default: prefix = '0;
         endcase
         r.sorted_count = prefix;
         r.done_res     = (prefix >= live_count());
         expected_q.push_back(r);
      endfunction

      function void check_result(logic signed [DATA_W-1:0] rd, logic [CNT_W-1:0] cnt,
                                 logic done);
         sort_result_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result: read_value %0d sorted_count %0d done_res %0b",
                     $time, rd, cnt, done);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (rd !== e.read_value) begin
            $display("%0t: read_value expected %0d actual %0d", $time, e.read_value, rd);
            errors++;
         end
         if (cnt !== e.sorted_count) begin
            $display("%0t: sorted_count expected %0d actual %0d", $time, e.sorted_count, cnt);
            errors++;
         end
         if (done !== e.done_res) begin
            $display("%0t: done_res expected %0b actual %0b", $time, e.done_res, done);
            errors++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [OP_W-1:0]          req_opcode = OP_LOAD;
   logic [IDX_W-1:0]         req_index = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [CNT_W-1:0]         rsp_sorted_count;
   logic                     rsp_done_res;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [1:0]               paddr = '0;
   logic [31:0]              pwdata = '0;
   logic [31:0]              prdata;
   logic                     pready;

   sort_scoreboard_type sb;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_ask = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int items_sent = 0;
   int cycles = 0;

   selection_sort_stepper dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_index(req_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_read_value(rsp_read_value),
      .rsp_sorted_count(rsp_sorted_count), .rsp_done_res(rsp_done_res),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // The receiver: checks each result item and stalls at random or for a long hold.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_read_value, rsp_sorted_count, rsp_done_res);
         if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            hold_left = HOLD_LEN;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] idx,
                            input logic signed [DATA_W-1:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_index  <= idx;
      req_value  <= val;
      do @(posedge clock); while (!(req_valid && !req_stall));
      sb.note_item(op, idx, val);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_element_count(input logic [31:0] data);
      logic [31:0] readback;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ELEMENT_COUNT;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_element_count(data);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback !== {{(32-CNT_W){1'b0}}, data[CNT_W-1:0]}) begin
         $display("%0t: element_count read back expected %0d actual %0d",
                  $time, data[CNT_W-1:0], readback);
         sb.errors++;
      end
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 32'h8000_0000;
      else if (r < 20) return 32'h7FFF_FFFF;
      else if (r < 25) return 32'h0;
      else if (r < 30) return 32'hFFFF_FFFF;
      else if (r < 50) return $urandom_range(8) - 4;
      else return $urandom;
   endfunction

   task automatic issue_step();
      int live;
      live = sb.live_count();
      if (sb.step_safe()) begin
         send_item(OP_STEP, IDX_W'($urandom), $urandom);
      end else begin
         for (int i = sb.prefix; i < live; i++) begin
            if (!sb.loaded[i]) begin
               send_item(OP_LOAD, IDX_W'(i), pick_value());
               break;
            end
         end
      end
   endtask

   task automatic issue_read();
      int slots [$];
      for (int i = 0; i < DEPTH; i++)
         if (sb.loaded[i]) slots.push_back(i);
      if (slots.size() == 0)
         send_item(OP_RESTART, IDX_W'($urandom), $urandom);
      else
         send_item(OP_READ, IDX_W'(slots[$urandom_range(slots.size() - 1)]), $urandom);
   endtask

   task automatic run_session(input logic [31:0] count_word, input bit press);
      int live;
      int budget;
      int r;
      int j;
      int tmp;
      int order [$];
      wait_idle();
      write_element_count(count_word);
      if (press) hold_ask++;
      live = sb.live_count();
      for (int i = 0; i < live; i++) order.push_back(i);
      for (int i = live - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         tmp      = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      foreach (order[i]) begin
         if ($urandom_range(99) < 10) issue_read();
         send_item(OP_LOAD, IDX_W'(order[i]), pick_value());
      end
      budget = 3 * live + 8;
      repeat (budget) begin
         r = $urandom_range(99);
         if (r < 60) issue_step();
         else if (r < 78) issue_read();
         else if (r < 90) send_item(OP_LOAD, IDX_W'($urandom), pick_value());
         else if (r < 94) send_item(OP_RESTART, IDX_W'($urandom), $urandom);
         else issue_step();
      end
      for (int i = 0; i < live; i++) send_item(OP_READ, IDX_W'(i), $urandom);
   endtask

   task automatic run_directed();
      send_item(OP_STEP, '0, '0);
      send_item(OP_RESTART, '1, '1);
      wait_idle();
      write_element_count(4);
      send_item(OP_LOAD, IDX_W'(0), 32'h7FFF_FFFF);
      send_item(OP_LOAD, IDX_W'(1), 32'h8000_0000);
      send_item(OP_LOAD, IDX_W'(2), 32'hFFFF_FFFF);
      send_item(OP_LOAD, IDX_W'(3), 32'h8000_0000);
      repeat (5) issue_step();
      for (int i = 0; i < 4; i++) send_item(OP_READ, IDX_W'(i), '0);
      wait_idle();
      write_element_count(2);
      send_item(OP_READ, IDX_W'(1), '0);
      send_item(OP_STEP, '0, '0);
      send_item(OP_RESTART, '0, '0);
      send_item(OP_STEP, '0, '0);
      send_item(OP_LOAD, IDX_W'(0), '0);
      send_item(OP_LOAD, IDX_W'(63), 32'h5555_5555);
      send_item(OP_READ, IDX_W'(63), '0);
      send_item(OP_LOAD, IDX_W'(63), 32'hAAAA_AAAA);
      send_item(OP_READ, IDX_W'(63), '1);
   endtask

   initial begin
      int sess;
      int r;
      int chosen;
      logic [31:0] count_word;
      sb = new();
      sb.clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      sess = 0;
      while (items_sent < ITEM_TARGET) begin
         case (sess % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 72; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 72; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         r = $urandom_range(99);
         if (r < 70) chosen = $urandom_range(8, 1);
         else if (r < 80) chosen = $urandom_range(16);
         else if (r < 88) chosen = DEPTH;
         else if (r < 94) chosen = $urandom_range(127, DEPTH + 1);
         else chosen = 0;
         count_word = ($urandom_range(1) != 0) ? ($urandom & 32'hFFFF_FF80) : 32'h0;
         count_word[CNT_W-1:0] = CNT_W'(chosen);
         run_session(count_word, sess == 4);
         sess++;
      end
      send_idle_pct = 0;
      wait_idle();
      repeat (DEPTH + 10) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
src/sss_pkg.sv
src/sss_cell.sv
src/selection_sort_stepper.sv
src/sss_checker.sv
tb/tb_selection_sort_stepper.sv
